@@ rtl/rts_pkg.sv @@
// ---------------------------------------------------------------------------
// rts_pkg: shared types and constants for the resistive touch sequencer
// Item formats, register indexes, event codes and the scaler handshake.
// ---------------------------------------------------------------------------
package rts_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int COORD_BITS  = 11;
  localparam int PROD_BITS   = SAMPLE_BITS + COORD_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int PRESS_W     = 10;
  localparam int KIND_W      = 2;

  localparam logic [PRESS_W-1:0] REPORT_PRESSURE = PRESS_W'(500);

  // Event codes
  localparam logic [KIND_W-1:0] EV_TOUCH  = 2'd0;
  localparam logic [KIND_W-1:0] EV_LIFT   = 2'd1;
  localparam logic [KIND_W-1:0] EV_REPORT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X      = 3'd6;

  typedef struct packed {
    logic                   pen_is_down;
    logic [SAMPLE_BITS-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]     event_kind;
    logic [COORD_BITS-1:0] screen_x;
    logic [COORD_BITS-1:0] screen_y;
    logic [PRESS_W-1:0]    pressure;
  } out_item_t;

  // Scaler request and response
  typedef struct packed {
    logic                   start;
    logic [SAMPLE_BITS-1:0] value;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [COORD_BITS-1:0]  res;
  } scale_req_t;

  typedef struct packed {
    logic                  done;
    logic [COORD_BITS-1:0] result;
  } scale_rsp_t;

endpackage

@@ rtl/rts_scaler.sv @@
// ---------------------------------------------------------------------------
// rts_scaler: serial axis scaler
// (value - lo) * res / (hi - lo), truncated, clamped to 0..res. A shift-add
// multiplier takes one bit of res per cycle, then a restoring divider
// retires one quotient bit per cycle in the same shift register.
// ---------------------------------------------------------------------------
module rts_scaler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rts_pkg::scale_req_t req_i,
  output rts_pkg::scale_rsp_t rsp_o
);

  localparam int SB    = rts_pkg::SAMPLE_BITS;
  localparam int CB    = rts_pkg::COORD_BITS;
  localparam int PB    = rts_pkg::PROD_BITS;
  localparam int CNT_W = $clog2(PB);

  typedef enum logic [1:0] {SC_IDLE, SC_MUL, SC_DIV, SC_FIN} sc_state_e;

  sc_state_e         state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PB-1:0]     acc_q, acc_d;
  logic [CB-1:0]     res_sh_q, res_sh_d;
  logic [CB-1:0]     res_q, res_d;
  logic [SB-1:0]     nmag_q, nmag_d;
  logic [SB-1:0]     dmag_q, dmag_d;
  logic [SB-1:0]     rem_q, rem_d;
  logic              neg_q, neg_d;
  logic              dzero_q, dzero_d;
  logic              done_q, done_d;
  logic [CB-1:0]     result_q, result_d;

  logic [SB:0]       n_diff, d_diff;
  logic [SB-1:0]     n_abs, d_abs;
  logic [SB:0]       rem_sh, rem_sub;
  logic              rem_ge;

  // Signed differences at start
  assign n_diff = {1'b0, req_i.value} - {1'b0, req_i.lo};
  assign d_diff = {1'b0, req_i.hi} - {1'b0, req_i.lo};
  assign n_abs  = n_diff[SB] ? SB'(~n_diff + 1'b1) : n_diff[SB-1:0];
  assign d_abs  = d_diff[SB] ? SB'(~d_diff + 1'b1) : d_diff[SB-1:0];

  // Restoring divider step
  assign rem_sh  = {rem_q, acc_q[PB-1]};
  assign rem_ge  = rem_sh >= {1'b0, dmag_q};
  assign rem_sub = rem_sh - {1'b0, dmag_q};

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    res_sh_d = res_sh_q;
    res_d    = res_q;
    nmag_d   = nmag_q;
    dmag_d   = dmag_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    dzero_d  = dzero_q;
    done_d   = 1'b0;
    result_d = result_q;
    unique case (state_q)
      SC_IDLE: begin
        if (req_i.start) begin
          nmag_d   = n_abs;
          dmag_d   = d_abs;
          neg_d    = n_diff[SB] ^ d_diff[SB];
          dzero_d  = (d_diff == '0);
          res_d    = req_i.res;
          res_sh_d = req_i.res;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = SC_MUL;
        end
      end
      SC_MUL: begin
        acc_d    = {acc_q[PB-2:0], 1'b0} + (res_sh_q[CB-1] ? PB'(nmag_q) : '0);
        res_sh_d = {res_sh_q[CB-2:0], 1'b0};
        if (cnt_q == CNT_W'(CB - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = SC_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      SC_DIV: begin
        rem_d = rem_ge ? rem_sub[SB-1:0] : rem_sh[SB-1:0];
        acc_d = {acc_q[PB-2:0], rem_ge};
        if (cnt_q == CNT_W'(PB - 1)) begin
          state_d = SC_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      SC_FIN: begin
        if (dzero_q || neg_q) begin
          result_d = '0;
        end else if (acc_q > PB'(res_q)) begin
          result_d = res_q;
        end else begin
          result_d = acc_q[CB-1:0];
        end
        done_d  = 1'b1;
        state_d = SC_IDLE;
      end
      default: state_d = SC_IDLE;
    endcase
  end

  // State, datapath and response registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SC_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      acc_q    <= '0;
      res_sh_q <= '0;
      res_q    <= '0;
      nmag_q   <= '0;
      dmag_q   <= '0;
      rem_q    <= '0;
      neg_q    <= 1'b0;
      dzero_q  <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      acc_q    <= acc_d;
      res_sh_q <= res_sh_d;
      res_q    <= res_d;
      nmag_q   <= nmag_d;
      dmag_q   <= dmag_d;
      rem_q    <= rem_d;
      neg_q    <= neg_d;
      dzero_q  <= dzero_d;
      result_q <= result_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

@@ rtl/resistive_touch_sequencer_top.sv @@
// ---------------------------------------------------------------------------
// resistive_touch_sequencer_top: resistive touchscreen poll sequencer
// Runs the pen-check / X / Y phase sequence over poll items and reports
// touch, lift and scaled position events.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i): one item per poll
//   tick with the pen-down line and the ADC sample of the current phase.
//   Output channel (out_valid_o / out_stall_i / out_item_o): at most one
//   event item per input item, held in an output register.
//   Config channel (cfg_valid_i / cfg_ready_o): always ready; write only
//   while the block is idle. Unknown indexes are ignored.
// Timing:
//   Touch and lift events are registered and appear in the cycle after the
//   input item is taken. Items that give no event or a touch/lift event do
//   not stall the input, unless the output register is held. A position
//   report runs both axes, X then Y, through one serial scaler, each with a
//   start step, a multiply phase, a divide phase and a final clamp step;
//   input is stalled meanwhile.
// Reset: phase 0, not touching, cache cleared, registers at their defaults.
// Output stall: the result waits in the output register; a new input item
// is taken only when that register is free or being emptied.
// ---------------------------------------------------------------------------
module resistive_touch_sequencer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rts_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output rts_pkg::out_item_t                   out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rts_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rts_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int SB = rts_pkg::SAMPLE_BITS;
  localparam int CB = rts_pkg::COORD_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN_X, ST_RUN_Y, ST_EMIT} st_state_e;
  typedef enum logic [1:0] {PH_PEN, PH_X, PH_Y, PH_UNUSED} phase_e;

  // Configuration registers
  logic [SB-1:0] raw_min_x_q, raw_max_x_q, raw_min_y_q, raw_max_y_q;
  logic [CB-1:0] screen_width_q, screen_height_q;
  logic          mirror_x_q;

  // Sequencer state
  st_state_e     state_q, state_d;
  phase_e        phase_q, phase_d;
  logic          touching_q, touching_d;
  logic [SB-1:0] latched_x_q, latched_x_d;
  logic [SB-1:0] cached_x_q, cached_x_d;
  logic [SB-1:0] cached_y_q, cached_y_d;
  logic [SB-1:0] job_y_q, job_y_d;
  logic [CB-1:0] res_x_q, res_x_d;
  logic          out_valid_q, out_valid_d;
  rts_pkg::out_item_t out_item_q, out_item_d;

  rts_pkg::scale_req_t scale_req;
  rts_pkg::scale_rsp_t scale_rsp;

  logic in_accept, out_free;
  logic [CB-1:0] x_final;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_min_x_q     <= SB'(48);
      raw_max_x_q     <= SB'(960);
      raw_min_y_q     <= SB'(110);
      raw_max_y_q     <= SB'(935);
      screen_width_q  <= CB'(1024);
      screen_height_q <= CB'(600);
      mirror_x_q      <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rts_pkg::REG_RAW_MIN_X:     raw_min_x_q     <= cfg_data_i[SB-1:0];
        rts_pkg::REG_RAW_MAX_X:     raw_max_x_q     <= cfg_data_i[SB-1:0];
        rts_pkg::REG_RAW_MIN_Y:     raw_min_y_q     <= cfg_data_i[SB-1:0];
        rts_pkg::REG_RAW_MAX_Y:     raw_max_y_q     <= cfg_data_i[SB-1:0];
        rts_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[CB-1:0];
        rts_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[CB-1:0];
        rts_pkg::REG_MIRROR_X:      mirror_x_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Scaler request: X from the idle state, Y when X finishes
  always_comb begin
    scale_req.start = 1'b0;
    if (state_q == ST_IDLE) begin
      scale_req.value = cached_x_q;
      scale_req.lo    = raw_min_x_q;
      scale_req.hi    = raw_max_x_q;
      scale_req.res   = screen_width_q;
      scale_req.start = in_accept && (phase_q == PH_Y) &&
                        (cached_x_q != '0) && (cached_y_q != '0);
    end else begin
      scale_req.value = job_y_q;
      scale_req.lo    = raw_min_y_q;
      scale_req.hi    = raw_max_y_q;
      scale_req.res   = screen_height_q;
      scale_req.start = (state_q == ST_RUN_X) && scale_rsp.done;
    end
  end

  rts_scaler u_scaler (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scale_req),
    .rsp_o  (scale_rsp)
  );

  assign x_final = mirror_x_q ? (screen_width_q - res_x_q) : res_x_q;

  // Phase sequence and output register
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    touching_d  = touching_q;
    latched_x_d = latched_x_q;
    cached_x_d  = cached_x_q;
    cached_y_d  = cached_y_q;
    job_y_d     = job_y_q;
    res_x_d     = res_x_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (phase_q)
            PH_PEN: begin
              if (in_item_i.pen_is_down) begin
                if (!touching_q) begin
                  touching_d  = 1'b1;
                  out_valid_d = 1'b1;
                  out_item_d  = '{event_kind: rts_pkg::EV_TOUCH, screen_x: '0,
                                  screen_y: '0, pressure: '0};
                end
                phase_d = PH_X;
              end else if (touching_q) begin
                touching_d  = 1'b0;
                cached_x_d  = '0;
                cached_y_d  = '0;
                out_valid_d = 1'b1;
                out_item_d  = '{event_kind: rts_pkg::EV_LIFT, screen_x: '0,
                                screen_y: '0, pressure: '0};
              end
            end
            PH_X: begin
              latched_x_d = in_item_i.adc_sample;
              phase_d     = PH_Y;
            end
            PH_Y: begin
              if (scale_req.start) begin
                job_y_d = cached_y_q;
                state_d = ST_RUN_X;
              end
              cached_x_d = latched_x_q;
              cached_y_d = in_item_i.adc_sample;
              phase_d    = PH_PEN;
            end
            default: phase_d = PH_PEN;
          endcase
        end
      end
      ST_RUN_X: begin
        if (scale_rsp.done) begin
          res_x_d = scale_rsp.result;
          state_d = ST_RUN_Y;
        end
      end
      ST_RUN_Y: begin
        if (scale_rsp.done) begin
          out_item_d = '{event_kind: rts_pkg::EV_REPORT, screen_x: x_final,
                         screen_y: scale_rsp.result,
                         pressure: rts_pkg::REPORT_PRESSURE};
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, job and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_PEN;
      touching_q  <= 1'b0;
      latched_x_q <= '0;
      cached_x_q  <= '0;
      cached_y_q  <= '0;
      job_y_q     <= '0;
      res_x_q     <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      touching_q  <= touching_d;
      latched_x_q <= latched_x_d;
      cached_x_q  <= cached_x_d;
      cached_y_q  <= cached_y_d;
      job_y_q     <= job_y_d;
      res_x_q     <= res_x_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ test/resistive_touch_sequencer_top_test.sv @@
// ---------------------------------------------------------------------------
// resistive_touch_sequencer_top_test: self-checking bench for the touch
// sequencer. It drives poll items and calibration writes, predicts the
// touch, lift and position events in a scoreboard and checks each event.
// ---------------------------------------------------------------------------
module resistive_touch_sequencer_top_test;

  localparam int SB     = rts_pkg::SAMPLE_BITS;
  localparam int CB     = rts_pkg::COORD_BITS;
  localparam int IDX_W  = rts_pkg::CFG_IDX_W;
  localparam int DATA_W = rts_pkg::CFG_DATA_W;

  localparam int SETTLE_CYCLES = 100;  // margin for a position report to run through the scaler
  localparam int ITEMS_PER_SETTING = 136;
  localparam int SETTINGS_RUN = 9;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    PH_PEN,
    PH_X,
    PH_Y,
    PH_UNUSED
  } poll_phase_e;

  // Scoreboard: tracks the sequence state and calibration, holds pending events
  class touch_scoreboard;
    logic [SB-1:0]          min_x, max_x, min_y, max_y;
    logic [CB-1:0]          width, height;
    logic                   mirror;
    poll_phase_e            phase;
    logic                   touching;
    logic [SB-1:0]          latched_x, cached_x, cached_y;
    rts_pkg::out_item_t     pending_events[$];
    int errors, polls, touches, lifts, reports;

    function new();
      min_x = 10'd48;
      max_x = 10'd960;
      min_y = 10'd110;
      max_y = 10'd935;
      width = 11'd1024;
      height = 11'd600;
      mirror = 1'b1;
      phase = PH_PEN;
      touching = 1'b0;
      latched_x = '0;
      cached_x = '0;
      cached_y = '0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        rts_pkg::REG_RAW_MIN_X:     min_x = data[SB-1:0];
        rts_pkg::REG_RAW_MAX_X:     max_x = data[SB-1:0];
        rts_pkg::REG_RAW_MIN_Y:     min_y = data[SB-1:0];
        rts_pkg::REG_RAW_MAX_Y:     max_y = data[SB-1:0];
        rts_pkg::REG_SCREEN_WIDTH:  width = data[CB-1:0];
        rts_pkg::REG_SCREEN_HEIGHT: height = data[CB-1:0];
        rts_pkg::REG_MIRROR_X:      mirror = data[0];
        default: ;
      endcase
    endfunction

    // signed (v - lo) * res / (hi - lo), truncated toward zero, clamped 0..res
    function logic [CB-1:0] scale_axis(logic [SB-1:0] v,
                                       logic [SB-1:0] lo,
                                       logic [SB-1:0] hi,
                                       logic [CB-1:0] res);
      int vi, loi, hii, resi, q;
      vi = v;
      loi = lo;
      hii = hi;
      resi = res;
      q = 0;
      if (hii != loi) q = ((vi - loi) * resi) / (hii - loi);
      if (q < 0) q = 0;
      if (q > resi) q = resi;
      return q[CB-1:0];
    endfunction

    function void note_poll(rts_pkg::in_item_t it);
      rts_pkg::out_item_t ev;
      logic [CB-1:0] x, y;
      ev = '0;
      polls++;
      case (phase)
        PH_PEN: begin
          if (it.pen_is_down) begin
            if (!touching) begin
              touching = 1'b1;
              ev.event_kind = rts_pkg::EV_TOUCH;
              pending_events.push_back(ev);
              touches++;
            end
            phase = PH_X;
          end else if (touching) begin
            touching = 1'b0;
            cached_x = '0;
            cached_y = '0;
            ev.event_kind = rts_pkg::EV_LIFT;
            pending_events.push_back(ev);
            lifts++;
          end
        end
        PH_X: begin
          latched_x = it.adc_sample;
          phase = PH_Y;
        end
        PH_Y: begin
          // report the previous pair only if both values are nonzero
          if (cached_x != 0 && cached_y != 0) begin
            x = scale_axis(cached_x, min_x, max_x, width);
            y = scale_axis(cached_y, min_y, max_y, height);
            if (mirror) x = width - x;
            ev.event_kind = rts_pkg::EV_REPORT;
            ev.screen_x = x;
            ev.screen_y = y;
            ev.pressure = rts_pkg::REPORT_PRESSURE;
            pending_events.push_back(ev);
            reports++;
          end
          cached_x = latched_x;
          cached_y = it.adc_sample;
          phase = PH_PEN;
        end
        default: phase = PH_PEN;
      endcase
    endfunction

    function void check_event(rts_pkg::out_item_t got);
      rts_pkg::out_item_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected event: event_kind %0d x %0d y %0d", got.event_kind,
               got.screen_x, got.screen_y);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
        errors++;
      end
      if (got.screen_x !== want.screen_x) begin
        $error("screen_x: expected %0d, actual %0d", want.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== want.screen_y) begin
        $error("screen_y: expected %0d, actual %0d", want.screen_y, got.screen_y);
        errors++;
      end
      if (got.pressure !== want.pressure) begin
        $error("pressure: expected %0d, actual %0d", want.pressure, got.pressure);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  rts_pkg::in_item_t     in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  rts_pkg::out_item_t    out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_index_i;
  logic [DATA_W-1:0]     cfg_data_i;

  touch_scoreboard sb;
  bit              quiet;  // no idling on either side while set
  int              n_settings;

  // Opening sequence under reset calibration: {pen_is_down, adc_sample}
  rts_pkg::in_item_t opener[] = '{
    {1'b0, 10'd1023},                                  // pen up, not touching
    {1'b1, 10'd0},                                     // touch started
    {1'b0, 10'd1023}, {1'b0, 10'd1023},                // pen ignored; cache empty
    {1'b1, 10'd0},                                     // ongoing touch
    {1'b1, 10'd0}, {1'b1, 10'd0},                      // report above range
    {1'b1, 10'd5}, {1'b1, 10'd0}, {1'b1, 10'd700},     // cache zero: no report
    {1'b1, 10'd0}, {1'b1, 10'd48}, {1'b1, 10'd110},    // cached x zero: no report
    {1'b1, 10'd0}, {1'b1, 10'd300}, {1'b1, 10'd300},   // report at calibration min
    {1'b0, 10'd512},                                   // lift clears the cache
    {1'b0, 10'd0},                                     // pen stays up
    {1'b1, 10'd1}, {1'b1, 10'd1}, {1'b1, 10'd1},       // touch, fresh pair
    {1'b1, 10'd1}, {1'b1, 10'd960}, {1'b1, 10'd935}    // report below range
  };

  resistive_touch_sequencer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("resistive_touch_sequencer_top_test: done, errors");
    $finish;
  end

  // Event receiver: random stall
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_event(out_item_o);
  end

  // Call at a falling edge; returns at a falling edge with valid still high
  task automatic send_poll(rts_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_poll(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(int lx, int hx, int ly, int hy, int w, int h, int mir);
    write_reg(rts_pkg::REG_RAW_MIN_X, DATA_W'(lx));
    write_reg(rts_pkg::REG_RAW_MAX_X, DATA_W'(hx));
    write_reg(rts_pkg::REG_RAW_MIN_Y, DATA_W'(ly));
    write_reg(rts_pkg::REG_RAW_MAX_Y, DATA_W'(hy));
    write_reg(rts_pkg::REG_SCREEN_WIDTH, DATA_W'(w));
    write_reg(rts_pkg::REG_SCREEN_HEIGHT, DATA_W'(h));
    write_reg(rts_pkg::REG_MIRROR_X, DATA_W'(mir));
    n_settings++;
  endtask

  // Stop input, wait for every pending event, then let the scaler go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly pen down so sequences run through; samples favor the rails
  function automatic rts_pkg::in_item_t random_poll();
    rts_pkg::in_item_t it;
    it.pen_is_down = ($urandom_range(0, 99) < 88);
    case ($urandom_range(0, 9))
      0:       it.adc_sample = '0;
      1:       it.adc_sample = '1;
      2:       it.adc_sample = SB'($urandom_range(1, 15));
      3:       it.adc_sample = SB'($urandom_range(1008, 1022));
      default: it.adc_sample = SB'($urandom_range(0, 1023));
    endcase
    return it;
  endfunction

  initial begin
    int s;
    sb = new();
    quiet = 1'b0;
    n_settings = 1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening, then random items under reset calibration
    foreach (opener[i]) send_poll(opener[i]);
    repeat (ITEMS_PER_SETTING - opener.size()) send_poll(random_poll());
    drain();

    for (s = 1; s < SETTINGS_RUN; s++) begin
      case (s)
        1: apply_setting(0, 1023, 0, 1023, 2047, 2047, 0);    // full range, widest
        2: apply_setting(512, 512, 0, 0, 1, 2047, 1);         // equal bounds
        3: begin                                              // reversed bounds
          apply_setting(1023, 0, 900, 100, 640, 480, 1);
          write_reg(REG_UNUSED, DATA_W'($urandom_range(0, 2047)));
        end
        4: apply_setting(48, 960, 110, 935, 0, 0, 1);         // zero resolution
        default: apply_setting($urandom_range(0, 2047), $urandom_range(0, 2047),
                               $urandom_range(0, 2047), $urandom_range(0, 2047),
                               $urandom_range(0, 2047), $urandom_range(0, 2047),
                               $urandom_range(0, 2047));
      endcase
      cfg_valid_i <= 1'b0;
      quiet = (s == 5);
      repeat (ITEMS_PER_SETTING) send_poll(random_poll());
      drain();
    end

    if (sb.pending_events.size() != 0) begin
      $error("%0d expected events never arrived", sb.pending_events.size());
      sb.errors++;
    end
    $display("Ran %0d poll items across %0d calibration settings.", sb.polls, n_settings);
    $display("Saw %0d touch, %0d lift and %0d position events.", sb.touches, sb.lifts,
             sb.reports);
    if (sb.errors == 0) begin
      $display("resistive_touch_sequencer_top_test: done, clean");
    end else begin
      $display("resistive_touch_sequencer_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rts_pkg.sv
rtl/rts_scaler.sv
rtl/resistive_touch_sequencer_top.sv
test/resistive_touch_sequencer_top_test.sv
